### rtl/cvt_pkg.sv
// Shared types and constants for the counted value table.
package cvt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int TOTAL_W     = $clog2(TABLE_DEPTH + 1);
  localparam int VALUE_W     = 32;
  localparam int OCC_W       = 16;
  localparam int ENTRIES_W   = 5;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);
  localparam logic [TOTAL_W-1:0]     TOTAL_FULL = TOTAL_W'(TABLE_DEPTH);

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef struct packed {
    logic                      func;
    logic signed [VALUE_W-1:0] value;
  } cvt_in_t;

  typedef struct packed {
    logic                 found;
    logic [OCC_W-1:0]     occurrences;
    logic [ENTRIES_W-1:0] entries;
    logic                 dropped;
  } cvt_out_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [COUNT_WIDTH-1:0]    count;
  } cvt_entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    cvt_entry_t        entry;
  } cvt_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_EMIT
  } cvt_state_t;

endpackage

### rtl/cvt_store.sv
// Entry storage: one write port and one registered read port.
module cvt_store import cvt_pkg::*; (
  input  logic              clk,
  input  cvt_wr_t           wr,
  input  logic [ADDR_W-1:0] rd_addr,
  output cvt_entry_t        rd_data
);

  cvt_entry_t mem [TABLE_DEPTH];
  cvt_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/cvt_seq.sv
// Sequencer that walks the stored entries with one comparator and updates the hit.
module cvt_seq import cvt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  cvt_in_t           item,
  input  logic              emit_ok,
  input  cvt_entry_t        rd_data,
  output logic [ADDR_W-1:0] rd_addr,
  output cvt_wr_t           wr,
  output logic              busy,
  output logic              emit,
  output cvt_out_t          result
);

  cvt_state_t             state_r, state_nxt;
  logic [TOTAL_W-1:0]     idx_r, idx_nxt;
  logic [TOTAL_W-1:0]     total_r, total_nxt;
  cvt_in_t                item_r, item_nxt;
  logic                   hit_r, hit_nxt;
  logic [ADDR_W-1:0]      hit_idx_r, hit_idx_nxt;
  logic [COUNT_WIDTH-1:0] hit_cnt_r, hit_cnt_nxt;
  cvt_out_t               res_r, res_nxt;
  logic                   at_end;
  logic                   match;
  logic [COUNT_WIDTH-1:0] bumped;

  assign at_end = (idx_r == total_r);
  assign match  = (rd_data.value == item_r.value);
  assign bumped = (hit_cnt_r == COUNT_MAX) ? hit_cnt_r : hit_cnt_r + COUNT_ONE;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (at_end || match) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_ok) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt     = idx_r;
    total_nxt   = total_r;
    item_nxt    = item_r;
    hit_nxt     = hit_r;
    hit_idx_nxt = hit_idx_r;
    hit_cnt_nxt = hit_cnt_r;
    res_nxt     = res_r;
    wr          = '0;
    busy        = 1'b1;
    emit        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy    = 1'b0;
        idx_nxt = '0;
        if (start) begin
          item_nxt = item;
          hit_nxt  = 1'b0;
        end
      end
      ST_SEARCH: begin
        if (at_end) begin
          hit_nxt = 1'b0;
        end else if (match) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = idx_r[ADDR_W-1:0];
          hit_cnt_nxt = rd_data.count;
        end else begin
          idx_nxt = idx_r + TOTAL_W'(1);
        end
      end
      ST_UPDATE: begin
        idx_nxt         = '0;
        res_nxt.found   = hit_r;
        res_nxt.dropped = 1'b0;
        res_nxt.occurrences = '0;
        if (item_r.func == FUNC_INSERT) begin
          if (hit_r) begin
            wr.en          = 1'b1;
            wr.addr        = hit_idx_r;
            wr.entry.value = item_r.value;
            wr.entry.count = bumped;
            res_nxt.occurrences = OCC_W'(bumped);
          end else if (total_r != TOTAL_FULL) begin
            wr.en          = 1'b1;
            wr.addr        = total_r[ADDR_W-1:0];
            wr.entry.value = item_r.value;
            wr.entry.count = COUNT_ONE;
            res_nxt.occurrences = OCC_W'(COUNT_ONE);
            total_nxt      = total_r + TOTAL_W'(1);
          end else begin
            res_nxt.dropped = 1'b1;
          end
        end else if (hit_r) begin
          res_nxt.occurrences = OCC_W'(hit_cnt_r);
        end
        res_nxt.entries = ENTRIES_W'(total_nxt);
      end
      ST_EMIT: begin
        idx_nxt = '0;
        emit    = emit_ok;
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  assign rd_addr = idx_nxt[ADDR_W-1:0];
  assign result  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      total_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      total_r <= total_nxt;
      hit_r   <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    hit_idx_r <= hit_idx_nxt;
    hit_cnt_r <= hit_cnt_nxt;
    res_r     <= res_nxt;
  end

endmodule

### rtl/counted_value_table.sv
// Top level of the counted value table.
//
// Each input item either inserts a signed 32-bit value or looks it up. An
// insert bumps the saturating count of a stored match, or appends the value
// with count 1; when all entries are used, a new value is dropped and flagged.
// A lookup changes nothing. Every item yields exactly one result item that
// carries found, the count after the item, the number of entries and dropped.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. The block takes one item at a time: in_stall is high while an
// item is being worked on. The single read port and comparator visit one entry
// per cycle, so the search visits the entries in order up to the match, or
// every stored entry on a miss. The sequencer then passes through its update
// state, which writes the entry and forms the result, and its emit state,
// which loads the output register, before it returns to idle. The
// next item may be accepted while the previous result still waits in the
// output register. When out_stall holds the result, a finished item waits in
// the sequencer until the output register frees.
// Reset empties the table; stored values need no clearing.
module counted_value_table import cvt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  cvt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output cvt_out_t out_data
);

  logic              busy;
  logic              start;
  logic              emit;
  logic              emit_ok;
  logic [ADDR_W-1:0] rd_addr;
  cvt_entry_t        rd_data;
  cvt_wr_t           wr;
  cvt_out_t          result;
  logic              out_valid_r, out_valid_nxt;
  cvt_out_t          out_data_r;

  assign in_stall = busy;
  assign start    = in_valid && !busy;
  assign emit_ok  = !out_valid_r || !out_stall;

  cvt_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .item    (in_data),
    .emit_ok (emit_ok),
    .rd_data (rd_data),
    .rd_addr (rd_addr),
    .wr      (wr),
    .busy    (busy),
    .emit    (emit),
    .result  (result)
  );

  cvt_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !(out_valid_r && out_stall))
    else $error("result loaded over a held result");

  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.found || out_data.occurrences != '0))
    else $error("found entry reports zero count");

  a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.dropped) |->
      (!out_data.found && out_data.occurrences == '0 &&
       out_data.entries == ENTRIES_W'(TABLE_DEPTH)))
    else $error("dropped item with inconsistent fields");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy)
    else $error("sequencer did not take accepted item");

endmodule

### dv/counted_value_table_tb.sv
// Testbench for the counted value table: random and directed items against a scoreboard.
`timescale 1ns / 100ps

module counted_value_table_tb import cvt_pkg::*;;

  localparam int RANDOM_ITEMS   = 1700;
  localparam int CALM_ITEMS     = 300;
  localparam int DRAIN_CYCLES   = 25;
  localparam int QUIET_LIMIT    = 1000;

  class count_table_scoreboard;
    logic signed [VALUE_W-1:0] seen_values[TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0]    seen_counts[TABLE_DEPTH];
    int                        seen_total;
    cvt_out_t                  owed_results[$];
    int                        mismatch_count;

    function new();
      seen_total     = 0;
      mismatch_count = 0;
    endfunction

    function void note_item(cvt_in_t item);
      cvt_out_t res;
      int       hit;
      hit = -1;
      res = '0;
      for (int i = 0; i < seen_total; i++) begin
        if (hit < 0 && seen_values[i] == item.value) begin
          hit = i;
        end
      end
      res.found = (hit >= 0);
      if (item.func == FUNC_INSERT) begin
        if (hit >= 0) begin
          if (seen_counts[hit] != COUNT_MAX) begin
            seen_counts[hit] = seen_counts[hit] + 1'b1;
          end
          res.occurrences = OCC_W'(seen_counts[hit]);
        end else if (seen_total < TABLE_DEPTH) begin
          seen_values[seen_total] = item.value;
          seen_counts[seen_total] = COUNT_ONE;
          res.occurrences = OCC_W'(COUNT_ONE);
          seen_total++;
        end else begin
          res.dropped = 1'b1;
        end
      end else if (hit >= 0) begin
        res.occurrences = OCC_W'(seen_counts[hit]);
      end
      res.entries = ENTRIES_W'(seen_total);
      owed_results.push_back(res);
    endfunction

    function void check_result(cvt_out_t got);
      cvt_out_t want;
      if (owed_results.size() == 0) begin
        $error("result arrived with none expected: %h", got);
        mismatch_count++;
        return;
      end
      want = owed_results.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, got.found);
        mismatch_count++;
      end
      if (got.occurrences !== want.occurrences) begin
        $error("occurrences: expected %0d, got %0d", want.occurrences, got.occurrences);
        mismatch_count++;
      end
      if (got.entries !== want.entries) begin
        $error("entries: expected %0d, got %0d", want.entries, got.entries);
        mismatch_count++;
      end
      if (got.dropped !== want.dropped) begin
        $error("dropped: expected %0d, got %0d", want.dropped, got.dropped);
        mismatch_count++;
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  cvt_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  cvt_out_t out_data;

  count_table_scoreboard board = new();
  bit idle_on = 1'b1;
  int quiet_cycles = 0;

  counted_value_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic send_item(input logic func, input logic signed [VALUE_W-1:0] value);
    cvt_in_t item;
    item.func  = func;
    item.value = value;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(item);
  endtask

  task automatic send_random_item();
    logic                      func;
    logic signed [VALUE_W-1:0] value;
    int                        pick;
    func = $urandom_range(0, 1) ? FUNC_LOOKUP : FUNC_INSERT;
    pick = $urandom_range(0, 99);
    if (board.seen_total != 0 && pick < 88) begin
      value = board.seen_values[$urandom_range(0, board.seen_total - 1)];
    end else if (board.seen_total != 0 && pick < 95) begin
      value = board.seen_values[$urandom_range(0, board.seen_total - 1)]
              ^ (32'h1 << $urandom_range(0, 31));
    end else begin
      value = $urandom();
    end
    send_item(func, value);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(FUNC_LOOKUP, 32'sh0000_0000);
    send_item(FUNC_INSERT, 32'sh8000_0000);
    send_item(FUNC_LOOKUP, 32'sh8000_0000);
    send_item(FUNC_INSERT, 32'sh8000_0000);
    send_item(FUNC_INSERT, 32'sh7fff_ffff);
    send_item(FUNC_INSERT, 32'sh0000_0000);
    send_item(FUNC_INSERT, 32'shffff_ffff);
    send_item(FUNC_LOOKUP, 32'sh0000_0001);
    send_item(FUNC_LOOKUP, 32'sh7fff_fffe);
    send_item(FUNC_LOOKUP, 32'sh7fff_ffff);
    send_item(FUNC_LOOKUP, 32'shffff_ffff);
    send_item(FUNC_INSERT, 32'sh0000_0000);
    send_item(FUNC_LOOKUP, 32'sh0000_0000);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_ITEMS) begin
        idle_on = 1'b0;
      end
      send_random_item();
    end
    in_valid <= 1'b0;

    while (board.owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatch_count == 0 && board.owed_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/cvt_pkg.sv
rtl/cvt_store.sv
rtl/cvt_seq.sv
rtl/counted_value_table.sv
dv/counted_value_table_tb.sv
